[rtl/cft_pkg.sv]
// Shared types, byte codes and helpers for the CSV field tokenizer.
`default_nettype none
package cft_pkg;

  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;
  localparam logic [7:0] BYTE_QUOTE  = 8'h22;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  localparam int COL_BITS_MAX = 16;
  localparam int SLOTS        = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_end;
    logic       row_end;
    logic [7:0] column;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic quoted;
    logic has_chars;
    logic row_closed;
  } line_flags_t;

  typedef struct packed {
    out_item_t        r2;
    out_item_t        r1;
    out_item_t        r0;
    logic [SLOTS-1:0] vld;
  } bundle_t;

  function automatic logic [7:0] col_sat8(input logic [COL_BITS_MAX-1:0] col);
    logic [7:0] res;
    if (col > COL_BITS_MAX'(255)) begin
      res = 8'hFF;
    end else begin
      res = col[7:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[rtl/cft_judge.sv]
// One judgment of a byte against the line flags, with one byte of lookahead.
`default_nettype none
module cft_judge #(
  parameter int COLUMN_BITS = 8
) (
  input  wire                        en,
  input  cft_pkg::line_flags_t       flags_i,
  input  wire  [COLUMN_BITS-1:0]     col_i,
  input  wire  [7:0]                 cur_byte,
  input  wire                        has_next,
  input  wire  [7:0]                 nxt_byte,
  input  wire  [7:0]                 delim,
  output cft_pkg::line_flags_t       flags_o,
  output logic [COLUMN_BITS-1:0]     col_o,
  output logic                       skip_set,
  output logic                       res_vld,
  output cft_pkg::out_item_t         res
);
  import cft_pkg::*;

  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

  logic       nxt_quote;
  logic       nxt_lf;
  logic [7:0] col8;

  assign nxt_quote = has_next && (nxt_byte == BYTE_QUOTE);
  assign nxt_lf    = has_next && (nxt_byte == BYTE_LF);
  assign col8      = col_sat8(COL_BITS_MAX'(col_i));

  always_comb begin
    flags_o      = flags_i;
    col_o        = col_i;
    skip_set     = 1'b0;
    res_vld      = 1'b0;
    res          = '0;
    res.column   = col8;
    if (en) begin
      if (flags_i.quoted) begin
        if (cur_byte == BYTE_QUOTE) begin
          if (nxt_quote) begin
            res_vld           = 1'b1;
            res.out_byte      = BYTE_QUOTE;
            flags_o.has_chars = 1'b1;
            skip_set          = 1'b1;
          end else begin
            flags_o.quoted = 1'b0;
          end
        end else begin
          res_vld           = 1'b1;
          res.out_byte      = cur_byte;
          flags_o.has_chars = 1'b1;
        end
      end else if (cur_byte == BYTE_QUOTE) begin
        flags_o.quoted = 1'b1;
      end else if (cur_byte == delim) begin
        res_vld       = 1'b1;
        res.field_end = 1'b1;
        res.row_end   = !has_next;
        if (!has_next) begin
          flags_o.row_closed = 1'b1;
        end else begin
          if (col_i != COL_MAX) begin
            col_o = col_i + COLUMN_BITS'(1);
          end
          flags_o.has_chars = 1'b0;
        end
      end else if ((cur_byte == BYTE_LF) || ((cur_byte == BYTE_CR) && !nxt_lf)) begin
        // empty first field at a row end: ignore the row end
        if ((col_i != '0) || flags_i.has_chars) begin
          res_vld            = 1'b1;
          res.field_end      = 1'b1;
          res.row_end        = 1'b1;
          flags_o.row_closed = 1'b1;
        end
      end else if (cur_byte != BYTE_CR) begin
        res_vld           = 1'b1;
        res.out_byte      = ((cur_byte != BYTE_TAB) && (cur_byte < BYTE_SPACE)) ?
                            BYTE_TILDE : cur_byte;
        flags_o.has_chars = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cft_queue.sv]
// Two-entry queue of result groups that hands out one result per transaction.
`default_nettype none
module cft_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  cft_pkg::bundle_t    push_data,
  output logic                full,
  output logic                out_valid,
  input  wire                 out_stall,
  output cft_pkg::out_item_t  out_data
);
  import cft_pkg::*;

  bundle_t          mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic [SLOTS-1:0] done_r;

  bundle_t          head;
  logic [SLOTS-1:0] remain;
  logic [SLOTS-1:0] sel;
  logic             head_last;
  logic             pop;
  logic             out_take;

  assign head      = mem_r[rd_ptr_r];
  assign remain    = head.vld & ~done_r;
  assign sel       = remain & (~remain + SLOTS'(1));
  assign head_last = (remain & ~sel) == '0;
  assign full      = count_r == 2'd2;
  assign out_valid = count_r != 2'd0;
  assign out_take  = out_valid && !out_stall;
  assign pop       = out_take && head_last;

  always_comb begin
    if (sel[0]) begin
      out_data = head.r0;
    end else if (sel[1]) begin
      out_data = head.r1;
    end else begin
      out_data = head.r2;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      done_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
        done_r   <= '0;
      end else if (out_take) begin
        done_r <= done_r | sel;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

[rtl/csv_field_tokenizer.sv]
// Top level of the CSV field tokenizer: line state, two byte judgments and result queue.
`default_nettype none
// Splits the bytes of a text line into fields, one input byte per transaction.
// A byte is held back one transaction so it can be judged with the next byte
// as lookahead; the byte marked is_last is judged at once and then the row is
// closed. All judgment for a transaction happens in the cycle it is accepted,
// so a byte can be taken every cycle while in_stall is low. Each byte yields
// zero to three results, which go into a two-entry group queue that hands out
// one result per cycle while out_stall is low; in_stall rises only when both
// queue entries are occupied. Sustained rate is one byte per cycle while
// out_stall is low and no byte yields more than one result; a burst of
// multi-result bytes fills both entries and holds the input until the head
// group drains, and the single output port then sets the pace at one result
// per cycle. The delimiter register may be written only while the block is
// idle; its reset value is a comma.
module csv_field_tokenizer #(
  parameter int COLUMN_BITS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr_en,
  input  wire  [7:0]           cfg_wr_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  cft_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output cft_pkg::out_item_t   out_data
);
  import cft_pkg::*;

  // line state
  logic [7:0]             delim_r;
  line_flags_t            flags_r,      flags_nxt;
  logic [COLUMN_BITS-1:0] col_r,        col_nxt;
  logic                   skip_r,       skip_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [7:0]             held_byte_r;

  // first judgment: the held byte, with the new byte as lookahead
  logic                   open0;
  logic                   en1;
  line_flags_t            flags1;
  logic [COLUMN_BITS-1:0] col1;
  logic                   skip1_set;
  logic                   v1;
  out_item_t              res1;
  logic                   skip_a;

  // second judgment: the last byte of the line, no lookahead
  logic                   en2;
  line_flags_t            flags2;
  logic [COLUMN_BITS-1:0] col2;
  logic                   skip2_set;
  logic                   v2;
  out_item_t              res2;

  logic                   v3;
  out_item_t              res3;
  bundle_t                bundle;
  logic                   accept;
  logic                   queue_full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = queue_full;

  assign open0 = held_valid_r && !flags_r.row_closed;
  assign en1   = open0 && !skip_r;

  cft_judge #(.COLUMN_BITS(COLUMN_BITS)) u_judge_held (
    .en       (en1),
    .flags_i  (flags_r),
    .col_i    (col_r),
    .cur_byte (held_byte_r),
    .has_next (1'b1),
    .nxt_byte (in_data.data_byte),
    .delim    (delim_r),
    .flags_o  (flags1),
    .col_o    (col1),
    .skip_set (skip1_set),
    .res_vld  (v1),
    .res      (res1)
  );

  // a pending skip swallows the second quote of a doubled pair
  assign skip_a = open0 ? (skip_r ? 1'b0 : skip1_set) : skip_r;
  assign en2    = in_data.is_last && !flags1.row_closed && !skip_a;

  cft_judge #(.COLUMN_BITS(COLUMN_BITS)) u_judge_last (
    .en       (en2),
    .flags_i  (flags1),
    .col_i    (col1),
    .cur_byte (in_data.data_byte),
    .has_next (1'b0),
    .nxt_byte (8'h00),
    .delim    (delim_r),
    .flags_o  (flags2),
    .col_o    (col2),
    .skip_set (skip2_set),
    .res_vld  (v2),
    .res      (res2)
  );

  // close the open field at the end of the line
  always_comb begin
    v3            = in_data.is_last && !flags2.row_closed;
    res3          = '0;
    res3.field_end = 1'b1;
    res3.row_end  = 1'b1;
    res3.column   = col_sat8(COL_BITS_MAX'(col2));
  end

  // group the results; mark the last one of the transaction
  always_comb begin
    bundle     = '0;
    bundle.r0  = res1;
    bundle.r1  = res2;
    bundle.r2  = res3;
    bundle.vld = {v3, v2 && !skip2_set, v1};
    if (v3) begin
      bundle.r2.run_last = 1'b1;
    end else if (v2) begin
      bundle.r1.run_last = 1'b1;
    end else if (v1) begin
      bundle.r0.run_last = 1'b1;
    end
  end

  // next line state: is_last returns everything but the delimiter to reset
  always_comb begin
    if (in_data.is_last) begin
      flags_nxt      = '0;
      col_nxt        = '0;
      skip_nxt       = 1'b0;
      held_valid_nxt = 1'b0;
    end else begin
      flags_nxt      = flags1;
      col_nxt        = col1;
      skip_nxt       = skip_a;
      held_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r      <= DELIM_RESET;
      flags_r      <= '0;
      col_r        <= '0;
      skip_r       <= 1'b0;
      held_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        delim_r <= cfg_wr_data;
      end
      if (accept) begin
        flags_r      <= flags_nxt;
        col_r        <= col_nxt;
        skip_r       <= skip_nxt;
        held_valid_r <= held_valid_nxt;
      end
    end
  end

  // hold the byte for lookahead; its valid flag gates every use
  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte_r <= in_data.data_byte;
    end
  end

  cft_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && (bundle.vld != '0)),
    .push_data (bundle),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/cft_checker.sv]
// Port-level checker for the CSV field tokenizer and its bind.
`default_nettype none
module cft_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_stall,
  input cft_pkg::out_item_t  out_data
);
  import cft_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.field_end |-> out_data.out_byte == 8'h00)
    else $error("field end carries a character");

  a_row_needs_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.field_end)
    else $error("row end without field end");

  a_row_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.row_end |-> out_data.run_last)
    else $error("row end followed by more results of the same byte");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
